// File: rtl/core/wheel_odometry_calibration_stats_core_assert.svh
// assertion macros for the wheel odometry calibration statistics core
`ifndef WHEEL_ODOMETRY_CALIBRATION_STATS_CORE_ASSERT_SVH
`define WHEEL_ODOMETRY_CALIBRATION_STATS_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define WOCS_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("wocs same-cycle check failed");
`define WOCS_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("wocs next-cycle check failed");
`else
`define WOCS_ASSERT_IMP(label, a, b)
`define WOCS_ASSERT_NEXT(label, a, b)
`endif
`endif

// File: rtl/core/wocs_pkg.sv
// shared types and constants of the wheel odometry calibration statistics core
package wocs_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_AW        = 4;

  // round(2^32 * 2 * pi / 60)
  localparam logic [31:0] TWO_PI_OVER_60_Q32 = 32'd449767924;

  localparam logic [16:0] GEAR_RST   = 17'd65536;
  localparam logic [30:0] BASE_RST   = 31'd38208;
  localparam logic [30:0] RADIUS_RST = 31'd65536;
  localparam logic [30:0] THRESH_RST = 31'd1311;

  typedef enum logic [1:0] {
    CFG_GEAR   = 2'd0,
    CFG_BASE   = 2'd1,
    CFG_RADIUS = 2'd2,
    CFG_THRESH = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [16:0] gear;
    logic [30:0] base;
    logic [30:0] radius;
    logic [30:0] thresh;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] rpm_front_left;
    logic signed [31:0] rpm_front_right;
    logic signed [31:0] rpm_rear_left;
    logic signed [31:0] rpm_rear_right;
    logic signed [31:0] odom_linear_vel;
    logic signed [31:0] yaw_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] gear_mean;
    logic signed [31:0] gear_max;
    logic signed [31:0] gear_min;
    logic [30:0]        gear_variance;
    logic [31:0]        gear_samples;
    logic signed [31:0] base_mean;
    logic signed [31:0] base_max;
    logic signed [31:0] base_min;
    logic [30:0]        base_variance;
    logic [31:0]        base_samples;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_K,
    OP_VL,
    OP_VR,
    OP_VLR,
    OP_VRR,
    OP_BDIV,
    OP_GDIV,
    OP_SQ,
    OP_MDIV,
    OP_VDIV
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_K,
    ST_VL,
    ST_VR,
    ST_BCHK,
    ST_VLR,
    ST_VRR,
    ST_BDIV,
    ST_BSQ,
    ST_BMDIV,
    ST_BVDIV,
    ST_GCHK,
    ST_GDIV,
    ST_GSQ,
    ST_GMDIV,
    ST_GVDIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t  op;
    logic go;
    logic sel_base;
    logic load_in;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic step_done;
    logic base_ok;
    logic gear_ok;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/core/wheel_odometry_calibration_stats_core.sv
// top level of the wheel odometry calibration statistics core
`include "wheel_odometry_calibration_stats_core_assert.svh"

// Wheel odometry calibration statistics. Each input item holds four motor rpm
// readings and the odometry linear and angular velocity (signed, FRAC_BITS
// fractional bits); each item yields exactly one result item holding the
// running mean, max, min, variance about nominal and sample count of the gear
// ratio and apparent baseline estimates. One item is worked at a time by a
// sequencer driving a shared shift-and-add multiplier (one multiplier bit a
// cycle) and a shared restoring divider. in_stall is low only while the
// sequencer is idle; the finished result sits in an output register, so a
// waiting result holds the next item only at its final step. Registers are
// written over the apb-style port at byte addresses 0 (nominal gear ratio),
// 4 (nominal baseline), 8 (wheel radius) and 12 (motion threshold), and
// should only be written while no item is in flight.
module wheel_odometry_calibration_stats_core #(
  parameter int FRAC_BITS = wocs_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  wocs_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output wocs_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wocs_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import wocs_pkg::*;

  cfg_t     cfg;
  cmd_t     cmd;
  stat_t    stat;
  cfg_idx_t reg_idx;
  logic     cfg_wr;

  // register index from the word address
  assign reg_idx = cfg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  // configuration registers, bits above each width are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gear   <= GEAR_RST;
      cfg.base   <= BASE_RST;
      cfg.radius <= RADIUS_RST;
      cfg.thresh <= THRESH_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        CFG_GEAR:   cfg.gear   <= pwdata[16:0];
        CFG_BASE:   cfg.base   <= pwdata[30:0];
        CFG_RADIUS: cfg.radius <= pwdata[30:0];
        CFG_THRESH: cfg.thresh <= pwdata[30:0];
        default:    cfg.gear   <= cfg.gear;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      CFG_GEAR:   prdata = {15'b0, cfg.gear};
      CFG_BASE:   prdata = {1'b0, cfg.base};
      CFG_RADIUS: prdata = {1'b0, cfg.radius};
      CFG_THRESH: prdata = {1'b0, cfg.thresh};
      default:    prdata = '0;
    endcase
  end

  // sequencer
  wocs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic, statistics and result register
  wocs_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg       (cfg),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  // an accepted item always starts the sequencer
  `WOCS_ASSERT_NEXT(a_busy_after_accept, (in_valid && !in_stall), in_stall)
  // a result is only loaded when the output register is free
  `WOCS_ASSERT_IMP(a_load_when_free, cmd.load_out, (!out_valid || !out_stall))
  // a result only appears through a load
  `WOCS_ASSERT_NEXT(a_valid_from_load, (!out_valid && !cmd.load_out), !out_valid)

endmodule

// File: rtl/core/wocs_mul.sv
// shift-and-add serial multiplier, one multiplier bit a cycle
module wocs_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [32:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [63:0] prod
);

  logic        busy;
  logic [63:0] acc;
  logic [63:0] ash;
  logic [31:0] b_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (!busy) begin
      busy <= go;
    end else if (b_r == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && go) begin
      acc <= '0;
      ash <= {31'b0, a};
      b_r <= b;
    end else if (busy && (b_r != '0)) begin
      if (b_r[0]) begin
        acc <= acc + ash;
      end
      ash <= ash << 1;
      b_r <= b_r >> 1;
    end
  end

  assign done = busy && (b_r == '0);
  assign prod = acc;

endmodule

// File: rtl/core/wocs_div.sv
// restoring serial divider, one quotient bit a cycle
module wocs_div #(
  parameter int DW = 50
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [DW-1:0] dvd,
  input  logic [32:0]   dvs,
  output logic          done,
  output logic [DW-1:0] quo
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [32:0]   rem;
  logic [32:0]   dvs_r;
  logic [DW-1:0] q;
  logic [34:0]   trial;

  assign trial = {1'b0, rem, q[DW-1]} - {2'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (!busy) begin
      busy <= go;
    end else if (cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && go) begin
      rem   <= '0;
      q     <= dvd;
      dvs_r <= dvs;
      cnt   <= CW'(DW);
    end else if (busy && (cnt != '0)) begin
      cnt <= cnt - 1'b1;
      if (!trial[34]) begin
        rem <= trial[32:0];
        q   <= {q[DW-2:0], 1'b1};
      end else begin
        rem <= {rem[31:0], q[DW-1]};
        q   <= {q[DW-2:0], 1'b0};
      end
    end
  end

  assign done = busy && (cnt == '0);
  assign quo  = q;

endmodule

// File: rtl/core/wocs_dp.sv
// datapath: item registers, shared multiplier and divider, statistics, output register
module wocs_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  wocs_pkg::cmd_t      cmd,
  output wocs_pkg::stat_t     stat,
  input  wocs_pkg::cfg_t      cfg,
  input  wocs_pkg::in_item_t  in_data,
  output wocs_pkg::out_item_t out_data,
  output logic                out_valid,
  input  logic                out_stall
);
  import wocs_pkg::*;

  localparam int DW = FRAC_BITS + 34;
  localparam longint ONE_L      = 64'sd1 << FRAC_BITS;
  localparam longint BMEAN_L    = ((64'sd583 << FRAC_BITS) + 64'sd500) / 64'sd1000;
  localparam longint THOUSAND_L = 64'sd1000 << FRAC_BITS;
  localparam logic signed [31:0] ONE_RST   = 32'(ONE_L);
  localparam logic signed [31:0] BMEAN_RST = 32'(BMEAN_L);
  localparam logic signed [31:0] BMIN_RST  =
    (THOUSAND_L > 64'sd2147483647) ? 32'sh7FFF_FFFF : 32'(THOUSAND_L);

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    logic [32:0] r;
    r = v[32] ? 33'(-v) : 33'(v);
    return r;
  endfunction

  function automatic logic signed [31:0] sat_sm(input logic [63:0] m, input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      r = (m >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(m[31:0]);
    end else begin
      r = (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
    end
    return r;
  endfunction

  in_item_t           in_r;
  logic [27:0]        k;
  logic signed [31:0] vl, vr, vlr, vrr, xs;
  logic [30:0]        d2;

  logic signed [31:0] g_mean, g_max, g_min, b_mean, b_max, b_min;
  logic [30:0]        g_var, b_var;
  logic [31:0]        g_cnt, b_cnt;

  logic signed [32:0] sum_l, sum_r, diff_b, s, ang33, lin33;
  logic signed [32:0] dev, mean_diff, var_diff;
  logic signed [31:0] cur_mean, cur_max, cur_min;
  logic [30:0]        cur_var;
  logic [31:0]        cur_cnt;
  logic [32:0]        nom, dm, n1;

  logic [32:0]        mul_a;
  logic [31:0]        mul_b;
  logic               mul_go, mul_done;
  logic [63:0]        prod, prod_f, prod_f1;
  logic [DW-1:0]      dvd, quo;
  logic [32:0]        dvs;
  logic               div_go, div_done;
  logic [32:0]        q33;
  logic signed [33:0] q_signed, mean_new, var_new;
  logic signed [31:0] x_div;
  logic [31:0]        cnt_new;

  assign sum_l  = {in_r.rpm_front_left[31], in_r.rpm_front_left}
                + {in_r.rpm_rear_left[31], in_r.rpm_rear_left};
  assign sum_r  = {in_r.rpm_front_right[31], in_r.rpm_front_right}
                + {in_r.rpm_rear_right[31], in_r.rpm_rear_right};
  assign diff_b = {vrr[31], vrr} - {vlr[31], vlr};
  assign s      = {vl[31], vl} + {vr[31], vr};
  assign ang33  = {in_r.yaw_rate[31], in_r.yaw_rate};
  assign lin33  = {in_r.odom_linear_vel[31], in_r.odom_linear_vel};

  assign cur_mean = cmd.sel_base ? b_mean : g_mean;
  assign cur_max  = cmd.sel_base ? b_max  : g_max;
  assign cur_min  = cmd.sel_base ? b_min  : g_min;
  assign cur_var  = cmd.sel_base ? b_var  : g_var;
  assign cur_cnt  = cmd.sel_base ? b_cnt  : g_cnt;
  assign nom      = cmd.sel_base ? {2'b0, cfg.base} : {16'b0, cfg.gear};

  assign dev       = {xs[31], xs} - $signed(nom);
  assign dm        = mag33(dev);
  assign mean_diff = {xs[31], xs} - {cur_mean[31], cur_mean};
  assign var_diff  = $signed({2'b0, d2}) - $signed({2'b0, cur_var});
  assign n1        = {1'b0, cur_cnt} + 33'd1;

  // operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    dvd   = '0;
    dvs   = '0;
    case (cmd.op)
      OP_K: begin
        mul_a = {2'b0, cfg.radius};
        mul_b = TWO_PI_OVER_60_Q32;
      end
      OP_VL: begin
        mul_a = mag33(sum_l);
        mul_b = {4'b0, k};
      end
      OP_VR: begin
        mul_a = mag33(sum_r);
        mul_b = {4'b0, k};
      end
      OP_VLR: begin
        mul_a = mag33({vl[31], vl});
        mul_b = {15'b0, cfg.gear};
      end
      OP_VRR: begin
        mul_a = mag33({vr[31], vr});
        mul_b = {15'b0, cfg.gear};
      end
      OP_SQ: begin
        mul_a = dm;
        mul_b = dm[31:0];
      end
      OP_BDIV: begin
        dvd = DW'(mag33(diff_b)) << FRAC_BITS;
        dvs = mag33(ang33);
      end
      OP_GDIV: begin
        dvd = DW'(mag33(lin33)) << (FRAC_BITS + 1);
        dvs = mag33(s);
      end
      OP_MDIV: begin
        dvd = DW'(mag33(mean_diff));
        dvs = n1;
      end
      OP_VDIV: begin
        dvd = DW'(mag33(var_diff));
        dvs = n1;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign mul_go = cmd.go && ((cmd.op == OP_K) || (cmd.op == OP_VL) || (cmd.op == OP_VR) ||
                             (cmd.op == OP_VLR) || (cmd.op == OP_VRR) || (cmd.op == OP_SQ));
  assign div_go = cmd.go && ((cmd.op == OP_BDIV) || (cmd.op == OP_GDIV) ||
                             (cmd.op == OP_MDIV) || (cmd.op == OP_VDIV));

  wocs_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (prod)
  );

  wocs_div #(.DW(DW)) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .dvd  (dvd),
    .dvs  (dvs),
    .done (div_done),
    .quo  (quo)
  );

  assign prod_f  = prod >> FRAC_BITS;
  assign prod_f1 = prod >> (FRAC_BITS + 1);
  assign q33     = quo[32:0];
  assign x_div   = sat_sm(64'(quo), (cmd.op == OP_BDIV)
                                    ? (diff_b[32] != ang33[32])
                                    : (lin33[32] != s[32]));
  // quotient sign follows the dividend
  assign q_signed = (cmd.op == OP_MDIV)
                    ? (mean_diff[32] ? -$signed({1'b0, q33}) : $signed({1'b0, q33}))
                    : (var_diff[32]  ? -$signed({1'b0, q33}) : $signed({1'b0, q33}));
  assign mean_new = {{2{cur_mean[31]}}, cur_mean} + q_signed;
  assign var_new  = $signed({3'b0, cur_var}) + q_signed;
  assign cnt_new  = (cur_cnt == '1) ? cur_cnt : cur_cnt + 32'd1;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (mul_done) begin
      case (cmd.op)
        OP_K:   k   <= prod[59:32];
        OP_VL:  vl  <= sat_sm(prod_f1, (!sum_l[32]) && (sum_l != '0));
        OP_VR:  vr  <= sat_sm(prod_f1, sum_r[32]);
        OP_VLR: vlr <= sat_sm(prod_f, vl[31]);
        OP_VRR: vrr <= sat_sm(prod_f, vr[31]);
        OP_SQ:  d2  <= (prod_f > 64'h7FFF_FFFF) ? '1 : prod_f[30:0];
        default: k  <= k;
      endcase
    end
    if (div_done && ((cmd.op == OP_BDIV) || (cmd.op == OP_GDIV))) begin
      xs <= x_div;
    end
  end

  // statistics registers
  always_ff @(posedge clk) begin
    if (rst) begin
      g_mean <= ONE_RST;
      g_max  <= '0;
      g_min  <= ONE_RST;
      g_var  <= '0;
      g_cnt  <= '0;
      b_mean <= BMEAN_RST;
      b_max  <= '0;
      b_min  <= BMIN_RST;
      b_var  <= '0;
      b_cnt  <= '0;
    end else if (div_done && (cmd.op == OP_MDIV)) begin
      if (cmd.sel_base) begin
        b_mean <= mean_new[31:0];
      end else begin
        g_mean <= mean_new[31:0];
      end
    end else if (div_done && (cmd.op == OP_VDIV)) begin
      if (cmd.sel_base) begin
        b_var <= var_new[30:0];
        b_cnt <= cnt_new;
        if (xs > cur_max) b_max <= xs;
        if (xs < cur_min) b_min <= xs;
      end else begin
        g_var <= var_new[30:0];
        g_cnt <= cnt_new;
        if (xs > cur_max) g_max <= xs;
        if (xs < cur_min) g_min <= xs;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.gear_mean     <= g_mean;
      out_data.gear_max      <= g_max;
      out_data.gear_min      <= g_min;
      out_data.gear_variance <= g_var;
      out_data.gear_samples  <= g_cnt;
      out_data.base_mean     <= b_mean;
      out_data.base_max      <= b_max;
      out_data.base_min      <= b_min;
      out_data.base_variance <= b_var;
      out_data.base_samples  <= b_cnt;
    end
  end

  assign stat.step_done = mul_done || div_done;
  assign stat.base_ok   = (in_r.yaw_rate != '0) && (mag33(ang33) >= {2'b0, cfg.thresh});
  assign stat.gear_ok   = (s != '0) && (mag33(lin33) >= {2'b0, cfg.thresh});
  assign stat.out_free  = !out_valid || !out_stall;

endmodule

// File: rtl/core/wocs_ctrl.sv
// sequencer that steps the datapath through one item
module wocs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  wocs_pkg::stat_t stat,
  output wocs_pkg::cmd_t  cmd
);
  import wocs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_K;
      ST_K:     if (stat.step_done) state_next = ST_VL;
      ST_VL:    if (stat.step_done) state_next = ST_VR;
      ST_VR:    if (stat.step_done) state_next = ST_BCHK;
      ST_BCHK:  state_next = stat.base_ok ? ST_VLR : ST_GCHK;
      ST_VLR:   if (stat.step_done) state_next = ST_VRR;
      ST_VRR:   if (stat.step_done) state_next = ST_BDIV;
      ST_BDIV:  if (stat.step_done) state_next = ST_BSQ;
      ST_BSQ:   if (stat.step_done) state_next = ST_BMDIV;
      ST_BMDIV: if (stat.step_done) state_next = ST_BVDIV;
      ST_BVDIV: if (stat.step_done) state_next = ST_GCHK;
      ST_GCHK:  state_next = stat.gear_ok ? ST_GDIV : ST_DONE;
      ST_GDIV:  if (stat.step_done) state_next = ST_GSQ;
      ST_GSQ:   if (stat.step_done) state_next = ST_GMDIV;
      ST_GMDIV: if (stat.step_done) state_next = ST_GVDIV;
      ST_GVDIV: if (stat.step_done) state_next = ST_DONE;
      ST_DONE:  if (stat.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op       = OP_NONE;
    cmd.sel_base = 1'b0;
    cmd.load_in  = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      ST_IDLE:  cmd.load_in = in_valid;
      ST_K:     cmd.op = OP_K;
      ST_VL:    cmd.op = OP_VL;
      ST_VR:    cmd.op = OP_VR;
      ST_VLR:   cmd.op = OP_VLR;
      ST_VRR:   cmd.op = OP_VRR;
      ST_BDIV:  cmd.op = OP_BDIV;
      ST_BSQ: begin
        cmd.op       = OP_SQ;
        cmd.sel_base = 1'b1;
      end
      ST_BMDIV: begin
        cmd.op       = OP_MDIV;
        cmd.sel_base = 1'b1;
      end
      ST_BVDIV: begin
        cmd.op       = OP_VDIV;
        cmd.sel_base = 1'b1;
      end
      ST_GDIV:  cmd.op = OP_GDIV;
      ST_GSQ:   cmd.op = OP_SQ;
      ST_GMDIV: cmd.op = OP_MDIV;
      ST_GVDIV: cmd.op = OP_VDIV;
      ST_DONE:  cmd.load_out = stat.out_free;
      default:  cmd.op = OP_NONE;
    endcase
    cmd.go = (cmd.op != OP_NONE);
  end

  assign in_stall = (state != ST_IDLE);

endmodule

// File: verif/tb_wheel_odometry_calibration_stats_core.sv
// testbench for the wheel odometry calibration statistics core
module tb_wheel_odometry_calibration_stats_core;
  import wocs_pkg::*;

  localparam int  FB         = FRAC_BITS_DEF;
  localparam int  IDLE_LIMIT = 20000;
  localparam int  SETTLE     = 600;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  // running statistics of one estimate
  typedef struct {
    longint          mean;
    longint          max;
    longint          min;
    longint          variance;
    longint unsigned count;
  } est_t;

  // calibration estimator: mirrors the register set and both estimates, keeps the
  // results still owed by the block and checks them in order
  class calib_scoreboard;
    longint unsigned nom_gear, nom_base, radius, thresh;
    est_t            gear_st, base_st;
    out_item_t       owed[$];
    int              errors;
    int              items_in, items_out;

    function new();
      nom_gear = GEAR_RST;
      nom_base = BASE_RST;
      radius   = RADIUS_RST;
      thresh   = THRESH_RST;
      gear_st  = '{mean: 64'sd1 <<< FB, max: 0, min: 64'sd1 <<< FB, variance: 0, count: 0};
      base_st  = '{mean: ((64'sd583 <<< FB) + 500) / 1000, max: 0,
                   min: sat32(64'sd1000 <<< FB), variance: 0, count: 0};
      errors   = 0;
      items_in = 0;
      items_out = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] value);
      case (idx)
        CFG_GEAR:   nom_gear = value[16:0];
        CFG_BASE:   nom_base = value[30:0];
        CFG_RADIUS: radius   = value[30:0];
        CFG_THRESH: thresh   = value[30:0];
        default: ;
      endcase
    endfunction

    function longint unsigned mag(longint a);
      return (a < 0) ? longint'(0) - a : a;
    endfunction

    function longint sat32(longint a);
      if (a > S32_MAX) return S32_MAX;
      if (a < S32_MIN) return S32_MIN;
      return a;
    endfunction

    // (a * b) >> sh, truncated toward zero
    function longint scale(longint a, longint unsigned b, int sh);
      longint unsigned m;
      m = (mag(a) * b) >> sh;
      return (a < 0) ? -longint'(m) : longint'(m);
    endfunction

    // (a << sh) / d, truncated toward zero, clipped to 32 bit
    function longint qdiv(longint a, int sh, longint d);
      longint unsigned q;
      q = (mag(a) << sh) / mag(d);
      if (q > 64'd2147483648) q = 64'd2147483648;
      return sat32(((a < 0) != (d < 0)) ? -longint'(q) : longint'(q));
    endfunction

    function longint tdiv(longint a, longint unsigned d);
      longint unsigned m;
      m = mag(a) / d;
      return (a < 0) ? -longint'(m) : longint'(m);
    endfunction

    function est_t fold(est_t e, longint x, longint unsigned nominal);
      longint unsigned n1, dm, sq;
      longint          d2;
      n1 = e.count + 1;
      dm = mag(x - longint'(nominal));
      sq = (dm * dm) >> FB;
      d2 = (sq > 64'd2147483647) ? S32_MAX : longint'(sq);
      if (x > e.max) e.max = x;
      if (x < e.min) e.min = x;
      e.mean     = e.mean + tdiv(x - e.mean, n1);
      e.variance = e.variance + tdiv(d2 - e.variance, n1);
      if (e.count < 64'hFFFF_FFFF) e.count++;
      return e;
    endfunction

    function void note_input(in_item_t d);
      longint unsigned k;
      longint          fl, fr, rl, rr, lin, ang, vl, vr, vlr, vrr, s;
      out_item_t       r;
      fl  = d.rpm_front_left;
      fr  = d.rpm_front_right;
      rl  = d.rpm_rear_left;
      rr  = d.rpm_rear_right;
      lin = d.odom_linear_vel;
      ang = d.yaw_rate;
      k   = (radius * longint'(TWO_PI_OVER_60_Q32)) >> 32;
      vl  = sat32(scale(-(fl + rl), k, FB + 1));
      vr  = sat32(scale(fr + rr, k, FB + 1));
      // apparent baseline from the gear-reduced wheel speed difference
      if (ang != 0 && mag(ang) >= thresh) begin
        vlr = sat32(scale(vl, nom_gear, FB));
        vrr = sat32(scale(vr, nom_gear, FB));
        base_st = fold(base_st, qdiv(vrr - vlr, FB, ang), nom_base);
      end
      // gear ratio from odometry speed over mean wheel speed
      s = vl + vr;
      if (s != 0 && mag(lin) >= thresh)
        gear_st = fold(gear_st, qdiv(lin, FB + 1, s), nom_gear);
      r.gear_mean     = gear_st.mean[31:0];
      r.gear_max      = gear_st.max[31:0];
      r.gear_min      = gear_st.min[31:0];
      r.gear_variance = gear_st.variance[30:0];
      r.gear_samples  = gear_st.count[31:0];
      r.base_mean     = base_st.mean[31:0];
      r.base_max      = base_st.max[31:0];
      r.base_min      = base_st.min[31:0];
      r.base_variance = base_st.variance[30:0];
      r.base_samples  = base_st.count[31:0];
      owed.push_back(r);
      items_in++;
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      items_out++;
      if (owed.size() == 0) begin
        $display("%0t: result with nothing owed, expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = owed.pop_front();
      cmp("gear_mean", want.gear_mean, got.gear_mean);
      cmp("gear_max", want.gear_max, got.gear_max);
      cmp("gear_min", want.gear_min, got.gear_min);
      cmp("gear_variance", {1'b0, want.gear_variance}, {1'b0, got.gear_variance});
      cmp("gear_samples", want.gear_samples, got.gear_samples);
      cmp("base_mean", want.base_mean, got.base_mean);
      cmp("base_max", want.base_max, got.base_max);
      cmp("base_min", want.base_min, got.base_min);
      cmp("base_variance", {1'b0, want.base_variance}, {1'b0, got.base_variance});
      cmp("base_samples", want.base_samples, got.base_samples);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  calib_scoreboard sb = new();
  bit  quiet = 1'b0;   // no idling on either side once set
  int  idle_cycles = 0;
  int  stall_left = 0;

  always #1 clk = ~clk;

  wheel_odometry_calibration_stats_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // handshake monitors: note accepted items, check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d quiet cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // receiver back-pressure in short random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // one item through the valid/stall handshake, with an occasional gap in front
  task automatic send_item(in_item_t d);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall);
  endtask

  // wait for the block to drain before touching a register
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // apb write: setup then access; junk above the register width is ignored
  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    logic [31:0] word;
    word = value;
    case (idx)
      CFG_GEAR: word[31:17] = 15'($urandom);
      default:  word[31]    = 1'($urandom);
    endcase
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({idx, 2'b00});
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, word);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_all(logic [31:0] gear, logic [31:0] base, logic [31:0] rad,
                         logic [31:0] thr);
    write_reg(CFG_GEAR, gear);
    write_reg(CFG_BASE, base);
    write_reg(CFG_RADIUS, rad);
    write_reg(CFG_THRESH, thr);
  endtask

  function automatic logic [31:0] edge_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'h0000_0001;
      4: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // mostly plausible driving: both sides turning with jitter, left mounted reversed
  function automatic in_item_t make_item();
    in_item_t d;
    int r, turn;
    if ($urandom_range(0, 9) == 0) begin
      d.rpm_front_left   = edge_value();
      d.rpm_front_right  = edge_value();
      d.rpm_rear_left    = edge_value();
      d.rpm_rear_right   = edge_value();
      d.odom_linear_vel  = edge_value();
      d.yaw_rate         = edge_value();
      return d;
    end
    r    = int'($urandom_range(0, 262144000)) - 131072000;
    turn = int'($urandom_range(0, 26214400)) - 13107200;
    d.rpm_front_left   = -(r - turn) + int'($urandom_range(0, 65536)) - 32768;
    d.rpm_rear_left    = -(r - turn) + int'($urandom_range(0, 65536)) - 32768;
    d.rpm_front_right  = r + turn + int'($urandom_range(0, 65536)) - 32768;
    d.rpm_rear_right   = r + turn + int'($urandom_range(0, 65536)) - 32768;
    d.odom_linear_vel  = int'($urandom_range(0, 262144)) - 131072;
    d.yaw_rate         = int'($urandom_range(0, 262144)) - 131072;
    // some slow or straight samples that fall under the threshold
    if ($urandom_range(0, 7) == 0) d.odom_linear_vel = int'($urandom_range(0, 2000)) - 1000;
    if ($urandom_range(0, 7) == 0) d.yaw_rate = 0;
    return d;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_item(make_item());
  endtask

  task automatic directed();
    in_item_t d;
    d = '0;
    send_item(d);                                        // standing still
    d = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0000, 32'h8000_0000};
    send_item(d);                                        // all fields at minimum
    d = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h7FFF_FFFF, 32'h7FFF_FFFF};
    send_item(d);                                        // all fields at maximum
    d = '{-32'sd65536000, 32'sd65536000, -32'sd65536000, 32'sd65536000,
          32'sd65536, 32'sd0};
    send_item(d);                                        // no yaw rate, baseline skipped
    d.odom_linear_vel = 32'sd1310;
    d.yaw_rate = 32'sd1311;
    send_item(d);                                        // just under and at threshold
    d.odom_linear_vel = -32'sd1311;
    d.yaw_rate = -32'sd1310;
    send_item(d);
    d = '{32'sd65536000, 32'sd65536000, 32'sd65536000, 32'sd65536000,
          32'sd65536, 32'sd65536};
    send_item(d);                                        // wheel speeds cancel, gear skipped
    d = '{-32'sd1, 32'sd1, 32'sd0, 32'sd0, 32'h7FFF_FFFF, 32'h8000_0000};
    send_item(d);                                        // tiny divisor, quotient clips
    d = '{32'sd100, -32'sd300, 32'sd50, -32'sd250, -32'sd65536, 32'sd65536};
    send_item(d);                                        // reversing
    d = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
          32'sd6553600, 32'sd6553600};
    send_item(d);                                        // wheel speeds saturate
    d = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h8000_0000, 32'h7FFF_FFFF};
    send_item(d);
    repeat (8) send_item(make_item());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings, rewritten explicitly with junk in the unused bits
    set_all(GEAR_RST, BASE_RST, RADIUS_RST, THRESH_RST);
    directed();
    run_random(300);

    // large wheels, everything counts, widest baseline reference
    drain();
    set_all(32'd65536, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
    directed();
    run_random(250);

    // zero gear and radius, only full-scale velocities pass the threshold
    drain();
    set_all(32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF);
    directed();
    run_random(120);

    // random plausible settings
    repeat (3) begin
      drain();
      set_all($urandom_range(0, 65536), $urandom_range(0, 131072),
              $urandom_range(3000, 26000), $urandom_range(0, 6000));
      run_random(120);
    end

    // final stretch with no idling on either side
    drain();
    set_all($urandom_range(1000, 65536), BASE_RST, $urandom_range(3000, 26000), THRESH_RST);
    quiet = 1'b1;
    run_random(400);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d items sent and %0d results checked over seven register settings",
             sb.items_in, sb.items_out);
    $display("%0d gear ratio and %0d baseline samples taken into the estimates",
             sb.gear_st.count, sb.base_st.count);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
